// File: rtl/hsvwl_pkg.sv
// Shared types, constants and arithmetic helpers for the HSV to RGB white lift unit.
`default_nettype none

package hsvwl_pkg;

  // Full scale of a byte channel, standing for 1.0.
  localparam logic [7:0]  BYTE_FULL   = 8'd255;
  // Bias that turns a floor division by 255 into a ceiling division.
  localparam logic [15:0] CEIL_BIAS   = 16'd254;
  // floor(w / 3) equals (w * 171) >> 9 for every byte w.
  localparam logic [7:0]  THIRD_RECIP = 8'd171;
  localparam int          THIRD_SHIFT = 9;
  localparam int          LIFT_W      = 7;

  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW     = 3'd0,
    SECTOR_YELLOW_GREEN   = 3'd1,
    SECTOR_GREEN_CYAN     = 3'd2,
    SECTOR_CYAN_BLUE      = 3'd3,
    SECTOR_BLUE_MAGENTA   = 3'd4,
    SECTOR_MAGENTA_RED    = 3'd5
  } sector_t;

  typedef struct packed {
    logic [15:0] hue_turn;
    logic [7:0]  saturation_level;
    logic [7:0]  value_level;
    logic [7:0]  white_level;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // First stage: sector split and the byte products.
  typedef struct packed {
    sector_t           sector;
    logic [15:0]       frac;
    logic [15:0]       vs;
    logic [15:0]       p_num;
    logic [7:0]        value;
    logic [LIFT_W-1:0] lift;
  } mul_t;

  // Second stage: the value-saturation-fraction product, split at bit 16.
  typedef struct packed {
    sector_t           sector;
    logic [15:0]       z_hi;
    logic              z_rem;
    logic [15:0]       vs;
    logic [7:0]        p;
    logic [7:0]        value;
    logic [LIFT_W-1:0] lift;
  } prod_t;

  // Third stage: the amounts taken off value to form q and t.
  typedef struct packed {
    sector_t           sector;
    logic [7:0]        q_cut;
    logic [7:0]        t_cut;
    logic [7:0]        p;
    logic [7:0]        value;
    logic [LIFT_W-1:0] lift;
  } cut_t;

  // floor(x / 255) for a 16-bit x whose quotient fits in a byte.
  // The estimate (x + x/256) / 256 is low by at most one, so a single
  // compare and increment finishes it.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    logic [8:0]  est;
    logic [16:0] back;
    logic [16:0] rem;
    sum  = {1'b0, x} + {9'b0, x[15:8]};
    est  = sum[16:8];
    back = {est, 8'b0} - {8'b0, est};
    rem  = {1'b0, x} - back;
    if (rem >= {9'b0, BYTE_FULL}) begin
      est = est + 9'd1;
    end
    return est[7:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/hsvwl_prod.sv
// Front two pipeline stages: sector split, byte products, wide product and p.
`default_nettype none

module hsvwl_prod (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  hsvwl_pkg::req_t  req,
  output logic             req_ready,
  input  logic             dn_ready,
  output logic             mul_valid,
  output logic             prod_valid,
  output hsvwl_pkg::prod_t prod
);

  hsvwl_pkg::mul_t  mul;
  hsvwl_pkg::mul_t  mul_next;
  hsvwl_pkg::prod_t prod_next;
  logic             prod_ready;
  logic [18:0]      scaled;
  logic [15:0]      third;
  logic [31:0]      z;

  assign prod_ready = !prod_valid || dn_ready;
  assign req_ready  = !mul_valid || prod_ready;

  always_comb begin
    scaled = {1'b0, req.hue_turn, 2'b0} + {2'b0, req.hue_turn, 1'b0};
    third  = {8'b0, req.white_level} * {8'b0, hsvwl_pkg::THIRD_RECIP};
    mul_next.sector = hsvwl_pkg::sector_t'(scaled[18:16]);
    mul_next.frac   = scaled[15:0];
    mul_next.vs     = {8'b0, req.value_level} * {8'b0, req.saturation_level};
    mul_next.p_num  = {8'b0, req.value_level}
                    * {8'b0, hsvwl_pkg::BYTE_FULL - req.saturation_level};
    mul_next.value  = req.value_level;
    mul_next.lift   = third[hsvwl_pkg::THIRD_SHIFT +: hsvwl_pkg::LIFT_W];
  end

  always_comb begin
    z = {16'b0, mul.vs} * {16'b0, mul.frac};
    prod_next.sector = mul.sector;
    prod_next.z_hi   = z[31:16];
    prod_next.z_rem  = |z[15:0];
    prod_next.vs     = mul.vs;
    prod_next.p      = hsvwl_pkg::div255(mul.p_num);
    prod_next.value  = mul.value;
    prod_next.lift   = mul.lift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        mul_valid <= req_valid;
      end
      if (prod_ready) begin
        prod_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      mul <= mul_next;
    end
    if (prod_ready && mul_valid) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsvwl_div.sv
// Third pipeline stage: ceiling divisions by 255 that give the q and t cuts.
`default_nettype none

module hsvwl_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             prod_valid,
  input  hsvwl_pkg::prod_t prod,
  output logic             prod_ready,
  input  logic             dn_ready,
  output logic             cut_valid,
  output hsvwl_pkg::cut_t  cut
);

  hsvwl_pkg::cut_t cut_next;
  logic [15:0]     q_num;
  logic [15:0]     t_num;

  assign prod_ready = !cut_valid || dn_ready;

  // q_num is ceil(v*s*f / 2^16) and t_num is ceil(v*s*(2^16 - f) / 2^16);
  // both stay at or below 65025, so adding the bias cannot overflow.
  always_comb begin
    q_num = prod.z_hi + {15'b0, prod.z_rem};
    t_num = prod.vs - prod.z_hi;
    cut_next.sector = prod.sector;
    cut_next.q_cut  = hsvwl_pkg::div255(q_num + hsvwl_pkg::CEIL_BIAS);
    cut_next.t_cut  = hsvwl_pkg::div255(t_num + hsvwl_pkg::CEIL_BIAS);
    cut_next.p      = prod.p;
    cut_next.value  = prod.value;
    cut_next.lift   = prod.lift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_valid <= 1'b0;
    end else if (prod_ready) begin
      cut_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      cut <= cut_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsvwl_mix.sv
// Last pipeline stage: q and t, sector channel selection and saturating white lift.
`default_nettype none

module hsvwl_mix (
  input  logic            clk,
  input  logic            rst,
  input  logic            cut_valid,
  input  hsvwl_pkg::cut_t cut,
  output logic            cut_ready,
  input  logic            rgb_stall,
  output logic            rgb_valid,
  output hsvwl_pkg::rgb_t rgb
);

  hsvwl_pkg::rgb_t rgb_next;
  logic [7:0]      q;
  logic [7:0]      t;
  logic [7:0]      r_raw;
  logic [7:0]      g_raw;
  logic [7:0]      b_raw;

  function automatic logic [7:0] lift_sat(input logic [7:0] c,
                                          input logic [hsvwl_pkg::LIFT_W-1:0] l);
    logic [8:0] sum;
    sum = {1'b0, c} + {{(9 - hsvwl_pkg::LIFT_W){1'b0}}, l};
    return sum[8] ? hsvwl_pkg::BYTE_FULL : sum[7:0];
  endfunction

  assign cut_ready = !rgb_valid || !rgb_stall;

  always_comb begin
    q = cut.value - cut.q_cut;
    t = cut.value - cut.t_cut;
    case (cut.sector)
      hsvwl_pkg::SECTOR_RED_YELLOW: begin
        r_raw = cut.value; g_raw = t;          b_raw = cut.p;
      end
      hsvwl_pkg::SECTOR_YELLOW_GREEN: begin
        r_raw = q;         g_raw = cut.value;  b_raw = cut.p;
      end
      hsvwl_pkg::SECTOR_GREEN_CYAN: begin
        r_raw = cut.p;     g_raw = cut.value;  b_raw = t;
      end
      hsvwl_pkg::SECTOR_CYAN_BLUE: begin
        r_raw = cut.p;     g_raw = q;          b_raw = cut.value;
      end
      hsvwl_pkg::SECTOR_BLUE_MAGENTA: begin
        r_raw = t;         g_raw = cut.p;      b_raw = cut.value;
      end
      default: begin
        r_raw = cut.value; g_raw = cut.p;      b_raw = q;
      end
    endcase
    rgb_next.red   = lift_sat(r_raw, cut.lift);
    rgb_next.green = lift_sat(g_raw, cut.lift);
    rgb_next.blue  = lift_sat(b_raw, cut.lift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (cut_ready) begin
      rgb_valid <= cut_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cut_ready && cut_valid) begin
      rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_white_lift_unit.sv
// Top level of the HSV to RGB converter with white lift.
`default_nettype none

// HSV to RGB converter with white lift. Each request transaction carries a
// 16-bit hue (a fraction of a full turn, so it wraps by its width), byte
// saturation and value on a scale where 255 means 1.0, and a byte white level.
// Each request gives exactly one RGB transaction of three bytes, in order.
// The hue is multiplied by six to give the sector and a 16-bit fraction; p, q
// and t are the exact products truncated to whole bytes; the channels are
// picked by sector in the usual six-way manner; and one third of the white
// level (truncated) is added to every channel, saturating at 255. The unit is
// a four-stage pipeline: byte products, the 16x16 fraction product, the
// divisions by 255, then channel selection and lift into the output register.
// A request may be taken every clock while the output side is not stalling.
// Its result passes through the mul, prod and cut registers into the output
// register, where it is held until it is handed off. Every
// stage has its own valid bit and advances when the stage after it is empty
// or moving, so bubbles are squeezed out and a stall on the output holds all
// data without loss. The req_stall output follows rgb_stall combinationally
// only when all four stages are full. There is no state besides the pipeline,
// so reset just empties it.
module hsv_to_rgb_white_lift_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  hsvwl_pkg::req_t req,
  output logic            rgb_valid,
  input  logic            rgb_stall,
  output hsvwl_pkg::rgb_t rgb
);

  logic             req_ready;
  logic             mul_valid;
  logic             prod_valid;
  logic             prod_ready;
  hsvwl_pkg::prod_t prod;
  logic             cut_valid;
  logic             cut_ready;
  hsvwl_pkg::cut_t  cut;
  logic [3:0]       stage_valid;

  assign req_stall   = !req_ready;
  assign stage_valid = {mul_valid, prod_valid, cut_valid, rgb_valid};

  // Stages one and two: sector split, byte products, then the wide product.
  hsvwl_prod u_prod (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_ready  (req_ready),
    .dn_ready   (prod_ready),
    .mul_valid  (mul_valid),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  // Stage three: the ceiling divisions that give how far q and t fall below value.
  hsvwl_div u_div (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_ready (prod_ready),
    .dn_ready   (cut_ready),
    .cut_valid  (cut_valid),
    .cut        (cut)
  );

  // Stage four: channel selection and white lift into the output register.
  hsvwl_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .cut_valid  (cut_valid),
    .cut        (cut),
    .cut_ready  (cut_ready),
    .rgb_stall  (rgb_stall),
    .rgb_valid  (rgb_valid),
    .rgb        (rgb)
  );

`ifndef ASSERT_OFF
  // The input may only be held off when every stage is full and the output stalls.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (stage_valid == 4'hF && rgb_stall))
    else $error("request held off while the pipeline has room");

  // A transaction taken in without one leaving adds exactly one full stage.
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && !(rgb_valid && !rgb_stall))
    |=> ($countones(stage_valid) == $countones($past(stage_valid)) + 1))
    else $error("accepted transaction lost or duplicated in the pipeline");

  // A transaction delivered without one entering frees exactly one stage.
  a_fill_shrinks: assert property (@(posedge clk) disable iff (rst)
    (!(req_valid && !req_stall) && rgb_valid && !rgb_stall)
    |=> ($countones(stage_valid) + 1 == $countones($past(stage_valid))))
    else $error("delivered transaction left a stray item in the pipeline");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (stage_valid == 4'h0))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
